FILE: src/nfba_pkg.sv
// nfba_pkg: shared types, constants and codes of the next-fit block allocator
// used by nfba_ctrl, nfba_dp and next_fit_block_allocator; no dependencies
package nfba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_BITS  = 16;
    localparam int ARENA_W    = ADDR_BITS + 1;
    localparam int HDR_W      = 7;
    localparam int ENTRY_W    = 2 * ADDR_BITS + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ARENA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ARENA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = CFG_IDX_W'(1);

    localparam logic [HDR_W-1:0]   HDR_MIN     = HDR_W'(1);
    localparam logic [HDR_W-1:0]   HDR_MAX     = HDR_W'(64);
    localparam logic [HDR_W-1:0]   HDR_RST     = HDR_W'(32);
    localparam logic [ARENA_W-1:0] ARENA_MIN   = ARENA_W'(65);
    localparam logic [ARENA_W-1:0] ARENA_MAX   = ARENA_W'(1) << ADDR_BITS;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_BADPTR   = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_NOINIT   = 3'd4;
    localparam logic [2:0] ST_REINIT   = 3'd5;

    typedef struct packed {
        logic [1:0]           op;
        logic [ADDR_BITS-1:0] req_size;
        logic [ADDR_BITS-1:0] payload_addr;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] result_addr;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] off;
        logic [ADDR_BITS-1:0] size;
        logic                 used;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_A_DEC, S_SWEEP, S_A_WNEW, S_A_WFOUND,
        S_F_RDP, S_F_RDN, S_F_RDE, S_F_CALC, S_F_WRITE, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        A_NONE, A_LATCH, A_INIT, A_SCAN_START, A_SCAN, A_SPLIT_DEC, A_SWEEP,
        A_WR_NEW, A_WR_FOUND, A_RD_PREV, A_RD_NEXT, A_RD_END, A_FREE_CALC,
        A_WR_MERGED, A_EMIT
    } t_act;

    typedef struct packed {
        t_act       act;
        logic       set_status;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       inited;
        logic       null_ptr;
        logic       scan_hit;
        logic       scan_miss;
        logic       chk_used;
        logic       split;
        logic       sweep_done;
    } t_dp_stat;

endpackage

FILE: src/nfba_ram.sv
// nfba_ram: generic single write port, single read port ram, registered read
// no dependencies
module nfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/nfba_ctrl.sv
// nfba_ctrl: sequencer of the allocator, issues one datapath command a cycle
// depends on nfba_pkg
module nfba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output nfba_pkg::t_cmd     o_cmd,
    input  nfba_pkg::t_dp_stat i_stat
);
    import nfba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.act        = A_NONE;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.act = A_LATCH;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_DONE;
                case (i_stat.op)
                    OP_INIT: begin
                        if (i_stat.inited) begin
                            o_cmd.status = ST_REINIT;
                        end else begin
                            o_cmd.act = A_INIT;
                        end
                    end
                    OP_ALLOC: begin
                        if (!i_stat.inited) begin
                            o_cmd.status = ST_NOINIT;
                        end else begin
                            o_cmd.act = A_SCAN_START;
                            n_state   = S_SCAN;
                        end
                    end
                    OP_FREE: begin
                        if (i_stat.null_ptr) begin
                            o_cmd.status = ST_OK;
                        end else if (!i_stat.inited) begin
                            o_cmd.status = ST_NOINIT;
                        end else begin
                            o_cmd.act = A_SCAN_START;
                            n_state   = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.act = A_SCAN;
                if (i_stat.scan_hit) begin
                    if (i_stat.op == OP_ALLOC) begin
                        n_state = S_A_DEC;
                    end else if (!i_stat.chk_used) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOTALLOC;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_F_RDP;
                    end
                end else if (i_stat.scan_miss) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = (i_stat.op == OP_ALLOC) ? ST_NOFIT : ST_BADPTR;
                    n_state          = S_DONE;
                end
            end
            S_A_DEC: begin
                o_cmd.act = A_SPLIT_DEC;
                n_state   = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.act = A_SWEEP;
                if (i_stat.sweep_done) begin
                    if (i_stat.op == OP_ALLOC) begin
                        n_state = i_stat.split ? S_A_WNEW : S_A_WFOUND;
                    end else begin
                        n_state = S_F_WRITE;
                    end
                end
            end
            S_A_WNEW: begin
                o_cmd.act = A_WR_NEW;
                n_state   = S_A_WFOUND;
            end
            S_A_WFOUND: begin
                o_cmd.act        = A_WR_FOUND;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_OK;
                n_state          = S_DONE;
            end
            S_F_RDP: begin
                o_cmd.act = A_RD_PREV;
                n_state   = S_F_RDN;
            end
            S_F_RDN: begin
                o_cmd.act = A_RD_NEXT;
                n_state   = S_F_RDE;
            end
            S_F_RDE: begin
                o_cmd.act = A_RD_END;
                n_state   = S_F_CALC;
            end
            S_F_CALC: begin
                o_cmd.act = A_FREE_CALC;
                n_state   = S_SWEEP;
            end
            S_F_WRITE: begin
                o_cmd.act        = A_WR_MERGED;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_OK;
                n_state          = S_DONE;
            end
            S_DONE: begin
                o_cmd.act = A_EMIT;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

FILE: src/nfba_dp.sv
// nfba_dp: block table ram, scan and move engines, config and result registers
// depends on nfba_pkg and nfba_ram
module nfba_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nfba_pkg::t_in_item             i_item,
    input  logic                           i_cfg_valid,
    input  logic [nfba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  nfba_pkg::t_cmd                 i_cmd,
    output nfba_pkg::t_dp_stat             o_stat,
    output nfba_pkg::t_out_item            o_result,
    output logic                           o_result_strobe
);
    import nfba_pkg::*;

    logic [ARENA_W-1:0]   r_cfg_arena;
    logic [HDR_W-1:0]     r_cfg_hdr;
    logic [ARENA_W-1:0]   r_arena;
    logic [HDR_W-1:0]     r_hdr;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_cursor;
    logic                 r_init;
    logic [1:0]           r_op;
    logic [ADDR_BITS-1:0] r_req;
    logic [ADDR_BITS-1:0] r_ptr;
    logic [IDX_W-1:0]     r_sc_rd;
    logic [CNT_W-1:0]     r_sc_left;
    logic                 r_sc_vld;
    logic [IDX_W-1:0]     r_sc_idx;
    logic [IDX_W-1:0]     r_f;
    t_entry               r_found;
    t_entry               r_prev;
    t_entry               r_next;
    logic                 r_split;
    logic [CNT_W-1:0]     r_sw_rd;
    logic [CNT_W-1:0]     r_sw_left;
    logic                 r_sw_up;
    logic [1:0]           r_sw_dist;
    logic                 r_sw_wvld;
    logic [IDX_W-1:0]     r_sw_widx;
    logic [IDX_W-1:0]     r_m;
    logic [ADDR_BITS-1:0] r_moff;
    logic [ADDR_BITS-1:0] r_msize;
    logic [2:0]           r_res_status;
    logic [ADDR_BITS-1:0] r_res_addr;
    logic                 r_out_vld;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_entry               rd_ent;

    nfba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = t_entry'(ram_rdata);

    // saturated config as latched by init
    logic [HDR_W-1:0]   hdr_sat;
    logic [ARENA_W-1:0] arena_sat;
    logic [ADDR_BITS-1:0] init_size;

    always_comb begin
        hdr_sat   = r_cfg_hdr;
        arena_sat = r_cfg_arena;
        if (r_cfg_hdr < HDR_MIN) hdr_sat = HDR_MIN;
        if (r_cfg_hdr > HDR_MAX) hdr_sat = HDR_MAX;
        if (r_cfg_arena < ARENA_MIN) arena_sat = ARENA_MIN;
        if (r_cfg_arena > ARENA_MAX) arena_sat = ARENA_MAX;
        init_size = ADDR_BITS'(arena_sat - ARENA_W'(hdr_sat));
    end

    // scan compare
    logic [CNT_W-1:0]   cnt_m1;
    logic               match;
    logic               scan_hit;
    logic               scan_miss;
    logic [ARENA_W-1:0] hdr_sum;

    always_comb begin
        cnt_m1  = r_count - CNT_W'(1);
        hdr_sum = ARENA_W'(rd_ent.off) + ARENA_W'(r_hdr);
        if (r_op == OP_ALLOC) begin
            match = !rd_ent.used && (rd_ent.size >= r_req);
        end else begin
            match = (hdr_sum == ARENA_W'(r_ptr));
        end
        scan_hit  = r_sc_vld && match;
        scan_miss = (r_sc_left == '0) && !scan_hit;
    end

    // split decision and new entries for allocate
    logic [ADDR_BITS-1:0] slack;
    logic                 split_now;
    logic [CNT_W-1:0]     f_ext;
    t_entry               new_ent;
    t_entry               alloc_ent;
    logic [ARENA_W-1:0]   alloc_addr;

    always_comb begin
        f_ext     = CNT_W'(r_f);
        slack     = r_found.size - r_req;
        split_now = (slack > ADDR_BITS'(r_hdr)) && (r_count < CNT_W'(MAX_BLOCKS));
        new_ent.off  = r_found.off + ADDR_BITS'(r_hdr) + r_req;
        new_ent.size = slack - ADDR_BITS'(r_hdr);
        new_ent.used = 1'b0;
        alloc_ent.off  = r_found.off;
        alloc_ent.size = r_req;
        alloc_ent.used = 1'b1;
        alloc_addr = ARENA_W'(r_found.off) + ARENA_W'(r_hdr);
    end

    // merge math for free
    logic               pf;
    logic               nf;
    logic [1:0]         nrem;
    logic [CNT_W-1:0]   e_idx;
    logic               has_end;
    logic [ARENA_W-1:0] end_off;
    logic [ADDR_BITS-1:0] off_m;
    logic [IDX_W-1:0]   m_idx;
    logic [ARENA_W-1:0] m_size;
    logic [IDX_W-1:0]   cur1;
    logic [IDX_W-1:0]   cur2;
    logic [IDX_W-1:0]   idx2;

    always_comb begin
        pf      = (r_f != '0) && !r_prev.used;
        nf      = ((f_ext + CNT_W'(1)) < r_count) && !r_next.used;
        nrem    = {1'b0, pf} + {1'b0, nf};
        e_idx   = f_ext + CNT_W'(1) + CNT_W'(nf);
        has_end = e_idx < r_count;
        if (has_end) begin
            end_off = nf ? ARENA_W'(rd_ent.off) : ARENA_W'(r_next.off);
        end else begin
            end_off = r_arena;
        end
        off_m  = pf ? r_prev.off : r_found.off;
        m_idx  = pf ? (r_f - IDX_W'(1)) : r_f;
        m_size = end_off - ARENA_W'(off_m) - ARENA_W'(r_hdr);
        // cursor follows each removed entry in turn
        cur1 = r_cursor;
        if (pf) begin
            if (r_cursor == r_f) cur1 = r_f - IDX_W'(1);
            else if (r_cursor > r_f) cur1 = r_cursor - IDX_W'(1);
        end
        idx2 = pf ? r_f : (r_f + IDX_W'(1));
        cur2 = cur1;
        if (nf) begin
            if (cur1 == idx2) cur2 = idx2 - IDX_W'(1);
            else if (cur1 > idx2) cur2 = cur1 - IDX_W'(1);
        end
    end

    // table port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = r_sc_rd;
        unique case (i_cmd.act)
            A_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {ADDR_BITS'(0), init_size, 1'b0};
            end
            A_SCAN: ram_raddr = r_sc_rd;
            A_SWEEP: begin
                ram_raddr = r_sw_rd[IDX_W-1:0];
                ram_we    = r_sw_wvld;
                ram_waddr = r_sw_widx;
                ram_wdata = ram_rdata;
            end
            A_WR_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_f + IDX_W'(1);
                ram_wdata = new_ent;
            end
            A_WR_FOUND: begin
                ram_we    = 1'b1;
                ram_waddr = r_f;
                ram_wdata = alloc_ent;
            end
            A_RD_PREV: ram_raddr = r_f - IDX_W'(1);
            A_RD_NEXT: ram_raddr = r_f + IDX_W'(1);
            A_RD_END:  ram_raddr = r_f + IDX_W'(2);
            A_WR_MERGED: begin
                ram_we    = 1'b1;
                ram_waddr = r_m;
                ram_wdata = {r_moff, r_msize, 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_arena <= ARENA_MAX;
            r_cfg_hdr   <= HDR_RST;
            r_count     <= '0;
            r_cursor    <= '0;
            r_init      <= 1'b0;
            r_sc_vld    <= 1'b0;
            r_sc_left   <= '0;
            r_sw_left   <= '0;
            r_sw_wvld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ARENA) r_cfg_arena <= i_cfg_data;
                if (i_cfg_index == CFG_HEADER) r_cfg_hdr <= i_cfg_data[HDR_W-1:0];
            end
            r_out_vld <= (i_cmd.act == A_EMIT);
            if (i_cmd.set_status) r_res_status <= i_cmd.status;
            unique case (i_cmd.act)
                A_LATCH: begin
                    r_op       <= i_item.op;
                    r_req      <= i_item.req_size;
                    r_ptr      <= i_item.payload_addr;
                    r_res_addr <= '0;
                end
                A_INIT: begin
                    r_hdr    <= hdr_sat;
                    r_arena  <= arena_sat;
                    r_count  <= CNT_W'(1);
                    r_cursor <= '0;
                    r_init   <= 1'b1;
                end
                A_SCAN_START: begin
                    r_sc_rd   <= (r_op == OP_ALLOC) ? r_cursor : '0;
                    r_sc_left <= r_count;
                    r_sc_vld  <= 1'b0;
                end
                A_SCAN: begin
                    if (scan_hit) begin
                        r_f      <= r_sc_idx;
                        r_found  <= rd_ent;
                        r_sc_vld <= 1'b0;
                        if (r_op == OP_ALLOC) r_cursor <= r_sc_idx;
                    end else begin
                        r_sc_vld <= (r_sc_left != '0);
                        if (r_sc_left != '0) begin
                            r_sc_idx  <= r_sc_rd;
                            r_sc_left <= r_sc_left - CNT_W'(1);
                            r_sc_rd   <= (CNT_W'(r_sc_rd) == cnt_m1) ? '0 : r_sc_rd + IDX_W'(1);
                        end
                    end
                end
                A_SPLIT_DEC: begin
                    r_split   <= split_now;
                    r_sw_up   <= 1'b1;
                    r_sw_dist <= 2'd1;
                    r_sw_rd   <= cnt_m1;
                    r_sw_wvld <= 1'b0;
                    r_sw_left <= split_now ? (cnt_m1 - f_ext) : '0;
                end
                A_SWEEP: begin
                    r_sw_wvld <= (r_sw_left != '0);
                    if (r_sw_left != '0) begin
                        r_sw_left <= r_sw_left - CNT_W'(1);
                        if (r_sw_up) begin
                            r_sw_widx <= r_sw_rd[IDX_W-1:0] + IDX_W'(1);
                            r_sw_rd   <= r_sw_rd - CNT_W'(1);
                        end else begin
                            r_sw_widx <= r_sw_rd[IDX_W-1:0] - IDX_W'(r_sw_dist);
                            r_sw_rd   <= r_sw_rd + CNT_W'(1);
                        end
                    end
                end
                A_WR_NEW: r_count <= r_count + CNT_W'(1);
                A_WR_FOUND: r_res_addr <= alloc_addr[ADDR_BITS-1:0];
                A_RD_NEXT: r_prev <= rd_ent;
                A_RD_END:  r_next <= rd_ent;
                A_FREE_CALC: begin
                    r_m       <= m_idx;
                    r_moff    <= off_m;
                    r_msize   <= m_size[ADDR_BITS-1:0];
                    r_cursor  <= cur2;
                    r_count   <= r_count - CNT_W'(nrem);
                    r_sw_up   <= 1'b0;
                    r_sw_dist <= nrem;
                    r_sw_rd   <= e_idx;
                    r_sw_wvld <= 1'b0;
                    r_sw_left <= ((nrem != 2'd0) && has_end) ? (r_count - e_idx) : '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.inited     = r_init;
        o_stat.null_ptr   = (r_ptr == '0);
        o_stat.scan_hit   = scan_hit;
        o_stat.scan_miss  = scan_miss;
        o_stat.chk_used   = rd_ent.used;
        o_stat.split      = r_split;
        o_stat.sweep_done = (r_sw_left == '0) && !r_sw_wvld;
    end

    assign o_result.status      = r_res_status;
    assign o_result.result_addr = r_res_addr;
    assign o_result_strobe      = r_out_vld;

    // the cursor always names a live table entry
    a_cursor_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (CNT_W'(r_cursor) < r_count))
        else $error("cursor beyond table");

    // table never overflows and never empties once set up
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> ((r_count != '0) && (r_count <= CNT_W'(MAX_BLOCKS))))
        else $error("block count out of range");

    // one result per request, never two beats back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |=> !r_out_vld)
        else $error("result strobe repeated");

    // a table move never runs while a scan still has data in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == A_SWEEP) |-> !r_sc_vld)
        else $error("move during scan");
endmodule

FILE: src/next_fit_block_allocator.sv
// next_fit_block_allocator: top level, joins the sequencer and the datapath
// depends on nfba_pkg, nfba_ctrl, nfba_dp (and nfba_ram below it)
//
// Next-fit allocator over an arena kept as an address-ordered table of up to
// MAX_BLOCKS blocks (header offset, payload size, used mark) held in one
// single-port-write, single-port-read table ram. A request is taken when start
// is high and busy is low; busy stays high until the request is finished, and
// then exactly one result beat appears on o_result with o_result_strobe high
// for one cycle. The receiver cannot stall: a beat is gone after its cycle.
// The next request may be started in the same cycle as the result beat.
// Allocate runs a next-fit search and free a search from entry 0; an allocate
// that splits moves the table entries after the found block up, and a free
// that merges moves the entries after the merged block down. The pace is set
// by the table ram's single read port: each search and every entry move read
// one entry per cycle.
// Configuration (index 0 arena bytes, index 1 header bytes) is always ready
// and takes effect at the next init, saturated to its legal range there.
// Table entries need no clearing after reset: only entries below the block
// count are ever used, and init writes the first one.
module next_fit_block_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  nfba_pkg::t_in_item              i_item,
    output nfba_pkg::t_out_item             o_result,
    output logic                            o_result_strobe,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nfba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nfba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nfba_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;
    logic     cfg_we;

    // config registers accept any beat; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // sequencer: one command a cycle, sees only start and datapath status
    nfba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // datapath: table ram, scan and move engines, result registers
    nfba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_cfg_valid     (cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );
endmodule

FILE: bench/tb_next_fit_block_allocator.sv
// tb_next_fit_block_allocator: self-checking bench for the next-fit block allocator
// needs nfba_pkg and next_fit_block_allocator; a scoreboard class predicts each beat
`timescale 1ns / 100ps

module tb_next_fit_block_allocator;
    import nfba_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 200;   // above the worst request latency
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // scoreboard: own copy of the allocator table plus the queue of expected beats
    class alloc_scoreboard;
        int unsigned arena_reg = 65536;
        int unsigned hdr_reg   = 32;
        int          blk_off[MAX_BLOCKS];
        int          blk_size[MAX_BLOCKS];
        bit          blk_used[MAX_BLOCKS];
        int          blk_cnt;
        int          cur;
        bit          inited;
        int          arena_len;
        int          hdr_len;
        t_out_item   pending[$];
        int          errors;

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ARENA) arena_reg = data;
            else if (idx == CFG_HEADER) hdr_reg = data[HDR_W-1:0];
        endfunction

        function void drop_entry(int i);
            for (int j = i; j < blk_cnt - 1; j++) begin
                blk_off[j] = blk_off[j+1];
                blk_size[j] = blk_size[j+1];
                blk_used[j] = blk_used[j+1];
            end
            blk_cnt--;
            if (cur == i) cur = i - 1;
            else if (cur > i) cur--;
        endfunction

        function logic [2:0] do_init();
            if (inited) return ST_REINIT;
            hdr_len = (hdr_reg < 1) ? 1 : (hdr_reg > 64) ? 64 : hdr_reg;
            arena_len = (arena_reg < 65) ? 65 : (arena_reg > 65536) ? 65536 : arena_reg;
            blk_off[0] = 0;
            blk_size[0] = arena_len - hdr_len;
            blk_used[0] = 0;
            blk_cnt = 1;
            cur = 0;
            inited = 1;
            return ST_OK;
        endfunction

        function logic [2:0] do_alloc(int req, output logic [ADDR_BITS-1:0] addr);
            int f;
            int n;
            bit hit;
            addr = '0;
            if (!inited) return ST_NOINIT;
            hit = 0;
            f = 0;
            // next-fit: from the cursor to the end, then wrap up to the cursor
            for (int i = cur; i < blk_cnt && !hit; i++)
                if (!blk_used[i] && blk_size[i] >= req) begin f = i; hit = 1; end
            for (int i = 0; i < cur && i < blk_cnt && !hit; i++)
                if (!blk_used[i] && blk_size[i] >= req) begin f = i; hit = 1; end
            if (!hit) return ST_NOFIT;
            cur = f;
            // split only when the slack beats a header and the table has room
            if (blk_size[f] - req > hdr_len && blk_cnt < MAX_BLOCKS) begin
                n = f + 1;
                for (int j = blk_cnt; j > n; j--) begin
                    blk_off[j] = blk_off[j-1];
                    blk_size[j] = blk_size[j-1];
                    blk_used[j] = blk_used[j-1];
                end
                blk_off[n] = blk_off[f] + hdr_len + req;
                blk_size[n] = blk_size[f] - req - hdr_len;
                blk_used[n] = 0;
                blk_cnt++;
            end
            blk_size[f] = req;
            blk_used[f] = 1;
            addr = ADDR_BITS'(blk_off[f] + hdr_len);
            return ST_OK;
        endfunction

        function logic [2:0] do_free(int p);
            int i;
            int m;
            int end_off;
            if (p == 0) return ST_OK;
            if (!inited) return ST_NOINIT;
            for (i = 0; i < blk_cnt; i++)
                if (blk_off[i] + hdr_len == p) break;
            if (i >= blk_cnt) return ST_BADPTR;
            if (!blk_used[i]) return ST_NOTALLOC;
            blk_used[i] = 0;
            m = i;
            if (m > 0 && !blk_used[m-1]) begin
                drop_entry(m);
                m--;
            end
            if (m + 1 < blk_cnt && !blk_used[m+1]) drop_entry(m + 1);
            // merged block takes all slack up to the next header or arena end
            end_off = (m + 1 < blk_cnt) ? blk_off[m+1] : arena_len;
            blk_size[m] = end_off - blk_off[m] - hdr_len;
            return ST_OK;
        endfunction

        function void note_request(t_in_item it);
            t_out_item r;
            r.result_addr = '0;
            r.status = ST_OK;
            case (it.op)
                OP_INIT:  r.status = do_init();
                OP_ALLOC: r.status = do_alloc(it.req_size, r.result_addr);
                OP_FREE:  r.status = do_free(it.payload_addr);
                default:  r.status = ST_OK;
            endcase
            pending.push_back(r);
        endfunction

        task check_beat(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat status %0d addr %0d",
                                 got.status, got.result_addr));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.result_addr !== want.result_addr)
                report($sformatf("result_addr %0d, expected %0d",
                                 got.result_addr, want.result_addr));
        endtask

        // payload offset of a random live used block, 0 when there is none
        function int pick_used();
            int idx[$];
            for (int i = 0; i < blk_cnt; i++)
                if (blk_used[i]) idx.push_back(i);
            if (idx.size() == 0) return 0;
            return blk_off[idx[$urandom_range(idx.size() - 1)]] + hdr_len;
        endfunction

        // payload offset of any live block, used or free
        function int pick_any();
            if (blk_cnt == 0) return $urandom_range(65535);
            return blk_off[$urandom_range(blk_cnt - 1)] + hdr_len;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_item              i_item;
    t_out_item             o_result;
    logic                  o_result_strobe;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    alloc_scoreboard sb;
    int              cycles;
    bit              no_gaps;   // stretch with back-to-back requests

    next_fit_block_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result beats last one cycle, so every strobe is taken at once
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) sb.check_beat(o_result);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_next_fit_block_allocator NOT OK");
            $finish;
        end
    end

    // one configuration beat; ready is sampled before the edge's updates
    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // one request beat; start stays high when the next request follows at once
    task send(logic [1:0] op, int req, int addr);
        t_in_item it;
        int gap;
        it.op = op;
        it.req_size = ADDR_BITS'(req);
        it.payload_addr = ADDR_BITS'(addr);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_request(it);
        gap = no_gaps ? 0 : $urandom_range(10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // idle point: all beats back, then past the worst latency
    task drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task random_request();
        int sel;
        int req;
        sel = $urandom_range(99);
        if (sel < 50) begin
            // mostly small sizes so the table fills up and splits run out
            case ($urandom_range(9))
                0:       req = $urandom_range(65535);
                1, 2:    req = $urandom_range(3000);
                default: req = $urandom_range(80);
            endcase
            send(OP_ALLOC, req, $urandom_range(65535));
        end else if (sel < 85) begin
            send(OP_FREE, $urandom_range(65535), sb.pick_used());
        end else if (sel < 92) begin
            // addresses of any live block, used or free
            send(OP_FREE, $urandom_range(65535), sb.pick_any());
        end else if (sel < 95) begin
            send(OP_FREE, $urandom_range(65535), $urandom_range(65535));
        end else if (sel < 97) begin
            send(OP_FREE, $urandom_range(65535), 0);
        end else if (sel < 99) begin
            send(OP_INIT, $urandom_range(65535), $urandom_range(65535));
        end else begin
            send(OP_UNKNOWN, $urandom_range(65535), $urandom_range(65535));
        end
    endtask

    initial begin
        int a0;
        sb = new();
        cycles = 0;
        no_gaps = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ARENA;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register extremes first, then the setting latched by init
        cfg_write(CFG_ARENA, 17'h1FFFF);
        cfg_write(CFG_HEADER, 17'h0007F);
        cfg_write(CFG_ARENA, 17'd0);
        cfg_write(CFG_HEADER, 17'd0);
        cfg_write(CFG_ARENA, CFG_DATA_W'(3000 + $urandom_range(1000)));
        cfg_write(CFG_HEADER, CFG_DATA_W'(1 + $urandom_range(15)));

        // requests before init, null free, unknown op, init and a second init
        send(OP_ALLOC, 16'hFFFF, 16'hFFFF);
        send(OP_FREE, 0, 5);
        send(OP_FREE, 0, 0);
        send(OP_UNKNOWN, 16'hFFFF, 16'hFFFF);
        send(OP_INIT, 0, 0);
        send(OP_INIT, 16'hFFFF, 16'hFFFF);
        // zero size, no fit, bad pointer, double free
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 16'hFFFF, 0);
        send(OP_FREE, 0, 1);
        send(OP_FREE, 0, 16'hFFFF);
        send(OP_ALLOC, 16, 0);
        a0 = sb.pick_used();
        send(OP_FREE, 0, a0);
        send(OP_FREE, 0, a0);
        send(OP_FREE, 0, 0);
        send(OP_ALLOC, 3000, 0);
        send(OP_FREE, 0, sb.pick_used());
        send(OP_FREE, 0, sb.pick_used());

        // sender holds off until everything is back, then more register writes
        drain();
        cfg_write(CFG_ARENA, 17'd65);
        cfg_write(CFG_HEADER, 17'd64);

        for (int n = 0; n < 1850; n++) begin
            if (n % 200 == 0) no_gaps = ($urandom_range(2) == 0);
            if (n == 900) begin
                drain();
                cfg_write(CFG_ARENA, 17'd65536);
                cfg_write(CFG_HEADER, 17'd1);
            end
            random_request();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_next_fit_block_allocator OK");
        end else begin
            $display("tb_next_fit_block_allocator NOT OK");
        end
        $finish;
    end

endmodule

FILE: next_fit_block_allocator.f
src/nfba_pkg.sv
src/nfba_ram.sv
src/nfba_ctrl.sv
src/nfba_dp.sv
src/next_fit_block_allocator.sv
bench/tb_next_fit_block_allocator.sv
